>>> hdl/uvst_pkg.sv
package uvst_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;

    localparam int WORD_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_PRESENT     = 2'd1;
    localparam logic [1:0] STAT_NOT_PRESENT = 2'd2;
    localparam logic [1:0] STAT_FULL        = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [5:0] position;
        logic [6:0] entry_count;
    } out_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_BITS-1:0]  addr;
        logic [WORD_BITS-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
    } ram_rd_t;

endpackage

>>> hdl/uvst_ram.sv
module uvst_ram #(
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/uvst_ctrl.sv
module uvst_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  uvst_pkg::in_t                  in_data,
    output logic                           res_valid,
    input  logic                           res_ready,
    output uvst_pkg::out_t                 res_data,
    output uvst_pkg::ram_wr_t              ram_wr,
    output uvst_pkg::ram_rd_t              ram_rd,
    input  logic [uvst_pkg::WORD_BITS-1:0] ram_rd_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [uvst_pkg::CNT_BITS-1:0]  count_reg, count_next;
    logic [uvst_pkg::CNT_BITS-1:0]  rd_idx_reg, rd_idx_next;
    logic [uvst_pkg::IDX_BITS-1:0]  cmp_idx_reg, cmp_idx_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [1:0]                     cmd_reg, cmd_next;
    logic [uvst_pkg::WORD_BITS-1:0] val_reg, val_next;
    logic [1:0]                     status_reg, status_next;
    logic                           found_reg, found_next;
    logic [5:0]                     pos_reg, pos_next;
    logic                           hit_now;
    logic                           miss_now;

    assign hit_now  = cmp_valid_reg && (ram_rd_data == val_reg);
    assign miss_now = !cmp_valid_reg && (rd_idx_reg == count_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res_data.status      = status_reg;
        res_data.found       = found_reg;
        res_data.position    = pos_reg;
        res_data.entry_count = 7'(count_reg);
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        ram_wr.en      = 1'b0;
        ram_wr.addr    = cmp_idx_reg - 1'b1;
        ram_wr.data    = ram_rd_data;
        ram_rd.en      = 1'b0;
        ram_rd.addr    = rd_idx_reg[uvst_pkg::IDX_BITS-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next       = in_data.cmd;
                    val_next       = uvst_pkg::WORD_BITS'(in_data.value);
                    rd_idx_next    = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit_now || miss_now) begin
                    cmp_valid_next = 1'b0;
                    found_next     = hit_now;
                    pos_next       = hit_now ? 6'(cmp_idx_reg) : 6'd0;
                    status_next    = hit_now ? uvst_pkg::STAT_OK : uvst_pkg::STAT_NOT_PRESENT;
                    state_next     = ST_DONE;
                    case (cmd_reg)
                        uvst_pkg::CMD_INSERT: begin
                            if (hit_now) begin
                                status_next = uvst_pkg::STAT_PRESENT;
                            end else if (count_reg == uvst_pkg::CNT_BITS'(uvst_pkg::CAPACITY))
                            begin
                                status_next = uvst_pkg::STAT_FULL;
                            end else begin
                                status_next = uvst_pkg::STAT_OK;
                                ram_wr.en   = 1'b1;
                                ram_wr.addr = count_reg[uvst_pkg::IDX_BITS-1:0];
                                ram_wr.data = val_reg;
                                pos_next    = 6'(count_reg);
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        uvst_pkg::CMD_DELETE: begin
                            if (hit_now) begin
                                rd_idx_next = uvst_pkg::CNT_BITS'(cmp_idx_reg) + 1'b1;
                                state_next  = ST_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (rd_idx_reg != count_reg) begin
                    ram_rd.en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[uvst_pkg::IDX_BITS-1:0];
                    rd_idx_next    = rd_idx_reg + 1'b1;
                end else begin
                    cmp_valid_next = 1'b0;
                end
            end
            ST_SHIFT: begin
                ram_wr.en = cmp_valid_reg;
                if (miss_now) begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end else if (rd_idx_reg != count_reg) begin
                    ram_rd.en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[uvst_pkg::IDX_BITS-1:0];
                    rd_idx_next    = rd_idx_reg + 1'b1;
                end else begin
                    cmp_valid_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
    end

endmodule

>>> hdl/unique_value_set_table.sv
// Channel  | Ports              | Payload          | Direction
// input    | s_valid, s_ready   | s_data  (in_t)   | in
// result   | m_valid, m_ready   | m_data  (out_t)  | out
//
// One item at a time; search reads one entry per cycle from the table RAM. A hit at
// index h, or a miss once all entries are read, ends the search (an empty table misses).
// Delete then moves later entries down one place (none for the last entry).
// The result then loads the output register and the controller returns to idle for
// the next transfer. Reset clears state, count and valid flags, not the table RAM.
// The RAM has a single read port. A result waits in the output register while the
// next item is taken; a full output register holds the controller in its done state.
module unique_value_set_table (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  uvst_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output uvst_pkg::out_t m_data
);

    uvst_pkg::ram_wr_t              ram_wr;
    uvst_pkg::ram_rd_t              ram_rd;
    logic [uvst_pkg::WORD_BITS-1:0] ram_rd_data;
    logic                           res_valid;
    logic                           res_ready;
    uvst_pkg::out_t                 res_data;
    logic                           m_valid_reg;
    uvst_pkg::out_t                 m_data_reg;

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    uvst_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .ram_wr      (ram_wr),
        .ram_rd      (ram_rd),
        .ram_rd_data (ram_rd_data)
    );

    uvst_ram #(
        .DEPTH     (uvst_pkg::CAPACITY),
        .ADDR_BITS (uvst_pkg::IDX_BITS),
        .DATA_BITS (uvst_pkg::WORD_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd.en),
        .rd_addr (ram_rd.addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res_data;
        end
    end

endmodule

>>> hdl/uvst_checker.sv
module uvst_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input uvst_pkg::out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == uvst_pkg::STAT_FULL |->
            !m_data.found && m_data.position == 6'd0 &&
            m_data.entry_count == 7'(uvst_pkg::CAPACITY))
        else $error("full status with inconsistent fields");

    a_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == uvst_pkg::STAT_PRESENT |-> m_data.found)
        else $error("duplicate reported without a match");

    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == uvst_pkg::STAT_NOT_PRESENT |->
            !m_data.found && m_data.position == 6'd0)
        else $error("miss reported with a match");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= 7'(uvst_pkg::CAPACITY))
        else $error("entry count above capacity");

endmodule

bind unique_value_set_table uvst_checker u_uvst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
